// ===== sv/per_source_intrusion_counter_defines.svh =====
// Assertion macros for the per-source intrusion counter.
// Used by the top level only; relies on signals named clk and rst in scope.
`ifndef PER_SOURCE_INTRUSION_COUNTER_DEFINES_SVH
`define PER_SOURCE_INTRUSION_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PSIC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PSIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/psic_pkg.sv =====
// Shared types and constants for the per-source intrusion counter.
// No dependencies; imported by the controller, the datapath, the top level and the testbench.
package psic_pkg;

  localparam int NUM_SOURCES_DEF      = 256;
  localparam int PORTS_PER_SOURCE_DEF = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BACKDOOR_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOS_EVENT_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECON_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOS_BYTE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOS_PACKET_LIMIT = 3'd4;

  localparam logic [15:0] BACKDOOR_LIMIT_RST   = 16'd50;
  localparam logic [15:0] DOS_EVENT_LIMIT_RST  = 16'd3;
  localparam logic [15:0] RECON_LIMIT_RST      = 16'd5;
  localparam logic [31:0] DOS_BYTE_LIMIT_RST   = 32'd100000;
  localparam logic [31:0] DOS_PACKET_LIMIT_RST = 32'd1000;

  localparam logic [2:0] SVC_SMTP = 3'd1;
  localparam logic [2:0] SVC_FTP  = 3'd4;

  localparam logic [15:0] LOW_PORT_BOUND = 16'd1024;
  localparam logic [15:0] TOP_PORT       = 16'd65535;
  localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] src_address;
    logic [15:0] dest_port;
    logic [2:0]  service_code;
    logic [31:0] src_byte_count;
    logic [31:0] dst_byte_count;
    logic [31:0] flow_packets;
  } in_t;

  typedef struct packed {
    logic        backdoor_hit;
    logic        dos_hit;
    logic        recon_hit;
    logic        table_full;
    logic        port_list_full;
    logic [31:0] backdoor_total;
    logic [31:0] dos_total;
    logic [31:0] recon_total;
  } out_t;

  typedef struct packed {
    logic load;
    logic key_rd;
    logic key_wr;
    logic table_full;
    logic stat_rd;
    logic stat_upd;
    logic is_new;
    logic port_rd;
    logic port_wr;
    logic port_full;
    logic stat_wr;
  } ctl_t;

  typedef struct packed {
    logic key_match;
    logic port_match;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT32) ? v : v + 32'd1;
  endfunction

endpackage

// ===== sv/psic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/psic_controller.sv =====
// Sequencing state machine of the per-source intrusion counter.
// Depends on psic_pkg; drives the datapath through ctl_t and reads sts_t.
module psic_controller import psic_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int PORTS_PER_SOURCE = PORTS_PER_SOURCE_DEF,
  localparam int SW  = $clog2(NUM_SOURCES),
  localparam int UW  = $clog2(NUM_SOURCES + 1),
  localparam int PCW = $clog2(PORTS_PER_SOURCE + 1),
  localparam int AW  = $clog2(NUM_SOURCES * PORTS_PER_SOURCE)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output ctl_t           ctl,
  input  sts_t           sts,
  input  logic [PCW-1:0] port_fill,
  output logic [SW-1:0]  key_addr,
  output logic [SW-1:0]  stat_addr,
  output logic [AW-1:0]  port_addr
);

  typedef enum logic [2:0] {
    IDLE, KSCAN, STATRD, STATUPD, PSCAN, STATWR
  } state_t;

  state_t         state;
  logic [UW-1:0]  kidx;
  logic [UW-1:0]  used;
  logic [SW-1:0]  slot;
  logic           is_new;
  logic           pend;
  logic [PCW-1:0] j;

  logic           key_hit;
  logic           port_hit;
  logic           k_more;
  logic           p_more;
  logic [PCW-1:0] pick;
  logic [UW-1:0]  kprev;

  assign key_hit  = pend && sts.key_match;
  assign port_hit = pend && sts.port_match;
  assign k_more   = kidx < used;
  assign p_more   = j < port_fill;
  assign kprev    = kidx - UW'(1);
  assign busy     = (state != IDLE);

  always_comb begin
    ctl = '0;
    ctl.is_new = is_new;
    case (state)
      IDLE: begin
        ctl.load = start;
      end
      KSCAN: begin
        if (!key_hit) begin
          if (k_more) begin
            ctl.key_rd = 1'b1;
          end else if (used == UW'(NUM_SOURCES)) begin
            ctl.table_full = 1'b1;
          end else begin
            ctl.key_wr = 1'b1;
          end
        end
      end
      STATRD: begin
        ctl.stat_rd = !is_new;
      end
      STATUPD: begin
        ctl.stat_upd = 1'b1;
      end
      PSCAN: begin
        if (!port_hit) begin
          if (p_more) begin
            ctl.port_rd = 1'b1;
          end else if (port_fill == PCW'(PORTS_PER_SOURCE)) begin
            ctl.port_full = 1'b1;
          end else begin
            ctl.port_wr = 1'b1;
          end
        end
      end
      STATWR: begin
        ctl.stat_wr = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign key_addr  = ctl.key_wr ? used[SW-1:0] : kidx[SW-1:0];
  assign stat_addr = slot;
  assign pick      = ctl.port_wr ? port_fill : j;
  assign port_addr = AW'(slot) * AW'(PORTS_PER_SOURCE) + AW'(pick);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      kidx   <= '0;
      used   <= '0;
      slot   <= '0;
      is_new <= 1'b0;
      pend   <= 1'b0;
      j      <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            kidx  <= '0;
            pend  <= 1'b0;
            state <= KSCAN;
          end
        end
        KSCAN: begin
          pend <= ctl.key_rd;
          if (key_hit) begin
            slot   <= kprev[SW-1:0];
            is_new <= 1'b0;
            state  <= STATRD;
          end else if (ctl.key_rd) begin
            kidx <= kidx + UW'(1);
          end else if (ctl.table_full) begin
            done  <= 1'b1;
            state <= IDLE;
          end else begin
            slot   <= used[SW-1:0];
            used   <= used + UW'(1);
            is_new <= 1'b1;
            state  <= STATRD;
          end
        end
        STATRD: begin
          state <= STATUPD;
        end
        STATUPD: begin
          j     <= '0;
          pend  <= 1'b0;
          state <= PSCAN;
        end
        PSCAN: begin
          pend <= ctl.port_rd;
          if (ctl.port_rd) begin
            j <= j + PCW'(1);
          end else begin
            state <= STATWR;
          end
        end
        STATWR: begin
          done  <= 1'b1;
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/psic_datapath.sv =====
// Datapath of the per-source intrusion counter: tables, counters and totals.
// Depends on psic_pkg and psic_ram; steered by psic_controller.
module psic_datapath import psic_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int PORTS_PER_SOURCE = PORTS_PER_SOURCE_DEF,
  localparam int SW  = $clog2(NUM_SOURCES),
  localparam int PCW = $clog2(PORTS_PER_SOURCE + 1),
  localparam int AW  = $clog2(NUM_SOURCES * PORTS_PER_SOURCE),
  localparam int STW = 64 + PCW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  in_t                   item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SW-1:0]         key_addr,
  input  logic [SW-1:0]         stat_addr,
  input  logic [AW-1:0]         port_addr,
  output sts_t                  sts,
  output logic [PCW-1:0]        port_fill,
  output out_t                  result
);

  logic [15:0] backdoor_limit;
  logic [15:0] dos_event_limit;
  logic [15:0] recon_limit;
  logic [31:0] dos_byte_limit;
  logic [31:0] dos_packet_limit;

  in_t         itm;
  logic [31:0] hp;
  logic [31:0] ov;
  logic [PCW-1:0] pc;
  logic        bd_hit, dos_hit, rc_hit, tf, pf;
  logic [31:0] bd_sum, dos_sum, rc_sum;

  logic [31:0]    key_rdata;
  logic [15:0]    port_rdata;
  logic [STW-1:0] stat_rdata;

  logic [31:0]    old_hp, old_ov, hp_new, ov_new;
  logic [PCW-1:0] old_pc, pc_inc;
  logic           named, hp_cond, ov_cond, bd_cond, dos_cond, rc_cond;

  psic_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES)) u_keys (
    .clk(clk), .we(ctl.key_wr), .waddr(key_addr), .wdata(itm.src_address),
    .re(ctl.key_rd), .raddr(key_addr), .rdata(key_rdata)
  );

  psic_ram #(.WIDTH(STW), .DEPTH(NUM_SOURCES)) u_stats (
    .clk(clk), .we(ctl.stat_wr), .waddr(stat_addr), .wdata({hp, ov, pc}),
    .re(ctl.stat_rd), .raddr(stat_addr), .rdata(stat_rdata)
  );

  psic_ram #(.WIDTH(16), .DEPTH(NUM_SOURCES * PORTS_PER_SOURCE)) u_ports (
    .clk(clk), .we(ctl.port_wr), .waddr(port_addr), .wdata(itm.dest_port),
    .re(ctl.port_rd), .raddr(port_addr), .rdata(port_rdata)
  );

  assign sts.key_match  = (key_rdata == itm.src_address);
  assign sts.port_match = (port_rdata == itm.dest_port);
  assign port_fill      = pc;

  assign old_hp = ctl.is_new ? 32'd0 : stat_rdata[STW-1 -: 32];
  assign old_ov = ctl.is_new ? 32'd0 : stat_rdata[PCW +: 32];
  assign old_pc = ctl.is_new ? '0 : stat_rdata[PCW-1:0];

  assign named    = (itm.service_code >= SVC_SMTP) && (itm.service_code <= SVC_FTP);
  assign hp_cond  = (itm.dest_port > LOW_PORT_BOUND) && (itm.dest_port < TOP_PORT) && !named;
  assign ov_cond  = (itm.flow_packets > dos_packet_limit) ||
                    (itm.src_byte_count > dos_byte_limit) ||
                    (itm.dst_byte_count > dos_byte_limit);
  assign hp_new   = hp_cond ? sat_inc(old_hp) : old_hp;
  assign ov_new   = ov_cond ? sat_inc(old_ov) : old_ov;
  assign bd_cond  = hp_cond && (hp_new > 32'(backdoor_limit));
  assign dos_cond = ov_cond && (ov_new > 32'(dos_event_limit));
  assign pc_inc   = pc + PCW'(1);
  assign rc_cond  = 32'(pc_inc) > 32'(recon_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      backdoor_limit   <= BACKDOOR_LIMIT_RST;
      dos_event_limit  <= DOS_EVENT_LIMIT_RST;
      recon_limit      <= RECON_LIMIT_RST;
      dos_byte_limit   <= DOS_BYTE_LIMIT_RST;
      dos_packet_limit <= DOS_PACKET_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BACKDOOR_LIMIT:   backdoor_limit   <= cfg_data[15:0];
        REG_DOS_EVENT_LIMIT:  dos_event_limit  <= cfg_data[15:0];
        REG_RECON_LIMIT:      recon_limit      <= cfg_data[15:0];
        REG_DOS_BYTE_LIMIT:   dos_byte_limit   <= cfg_data;
        REG_DOS_PACKET_LIMIT: dos_packet_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bd_sum  <= '0;
      dos_sum <= '0;
      rc_sum  <= '0;
      bd_hit  <= 1'b0;
      dos_hit <= 1'b0;
      rc_hit  <= 1'b0;
      tf      <= 1'b0;
      pf      <= 1'b0;
    end else begin
      if (ctl.load) begin
        bd_hit  <= 1'b0;
        dos_hit <= 1'b0;
        rc_hit  <= 1'b0;
        tf      <= 1'b0;
        pf      <= 1'b0;
      end
      if (ctl.table_full) begin
        tf <= 1'b1;
      end
      if (ctl.stat_upd) begin
        bd_hit <= bd_cond;
        dos_hit <= dos_cond;
        if (bd_cond) begin
          bd_sum <= sat_inc(bd_sum);
        end
        if (dos_cond) begin
          dos_sum <= sat_inc(dos_sum);
        end
      end
      if (ctl.port_full) begin
        pf <= 1'b1;
      end
      if (ctl.port_wr && rc_cond) begin
        rc_hit <= 1'b1;
        rc_sum <= sat_inc(rc_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      itm <= item;
    end
    if (ctl.stat_upd) begin
      hp <= hp_new;
      ov <= ov_new;
      pc <= old_pc;
    end else if (ctl.port_wr) begin
      pc <= pc_inc;
    end
  end

  always_comb begin
    result.backdoor_hit   = bd_hit;
    result.dos_hit        = dos_hit;
    result.recon_hit      = rc_hit;
    result.table_full     = tf;
    result.port_list_full = pf;
    result.backdoor_total = bd_sum;
    result.dos_total      = dos_sum;
    result.recon_total    = rc_sum;
  end

endmodule

// ===== sv/per_source_intrusion_counter.sv =====
// Per-source intrusion counter, top level: controller plus datapath.
// Depends on psic_pkg, psic_controller, psic_datapath and the defines header.
//
// A flow record is taken when start is high and busy is low, and done is high
// for exactly one cycle with its result on result; the receiver cannot stall
// it. The source table and then the port list are each searched one entry per
// clock through the single read port of their RAM. Register writes are to be
// made only while busy is low; the block itself does not enforce this. Writes
// take effect at once.
`include "per_source_intrusion_counter_defines.svh"

module per_source_intrusion_counter import psic_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int PORTS_PER_SOURCE = PORTS_PER_SOURCE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_t                   item,
  output logic                  done,
  output out_t                  result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW  = $clog2(NUM_SOURCES);
  localparam int PCW = $clog2(PORTS_PER_SOURCE + 1);
  localparam int AW  = $clog2(NUM_SOURCES * PORTS_PER_SOURCE);

  ctl_t           ctl;
  sts_t           sts;
  logic [PCW-1:0] port_fill;
  logic [SW-1:0]  key_addr;
  logic [SW-1:0]  stat_addr;
  logic [AW-1:0]  port_addr;

  psic_controller #(
    .NUM_SOURCES(NUM_SOURCES), .PORTS_PER_SOURCE(PORTS_PER_SOURCE)
  ) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .ctl(ctl), .sts(sts), .port_fill(port_fill),
    .key_addr(key_addr), .stat_addr(stat_addr), .port_addr(port_addr)
  );

  psic_datapath #(
    .NUM_SOURCES(NUM_SOURCES), .PORTS_PER_SOURCE(PORTS_PER_SOURCE)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .item(item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .key_addr(key_addr), .stat_addr(stat_addr), .port_addr(port_addr),
    .sts(sts), .port_fill(port_fill), .result(result)
  );

  `PSIC_ASSERT_SAME(a_done_idle, done, !busy, "Result shown while a transaction is in progress.")
  `PSIC_ASSERT_NEXT(a_start_busy, start && !busy, busy, "Accepted transaction did not start.")
  `PSIC_ASSERT_NEXT(a_done_single, done, !done, "Result strobe held for more than one cycle.")
  `PSIC_ASSERT_SAME(a_full_quiet, done && result.table_full,
    !result.backdoor_hit && !result.dos_hit && !result.recon_hit && !result.port_list_full,
    "Ignored record reported a detection.")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the per-source intrusion counter.
// Depends on psic_pkg and the per_source_intrusion_counter top level; flow
// records are predicted in the testbench and each result is compared in order.
`timescale 1ns / 1ps

module tb_top;
  import psic_pkg::*;

  localparam int NSRC = NUM_SOURCES_DEF;
  localparam int NPORT = PORTS_PER_SOURCE_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t item = '0;
  logic done;
  out_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  per_source_intrusion_counter uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] lim_backdoor, lim_dos_event, lim_recon, lim_bytes, lim_packets;
  logic [31:0] src_keys [NSRC];
  int unsigned src_count;
  logic [31:0] hp_cnt [NSRC];
  logic [31:0] ov_cnt [NSRC];
  logic [15:0] port_store [NSRC][NPORT];
  int unsigned port_cnt [NSRC];
  logic [31:0] sum_backdoor, sum_dos, sum_recon;

  out_t verdicts_due[$];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 35;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic out_t score_flow(input in_t r);
    out_t o;
    int unsigned slot;
    bit hit;
    bit known;
    o = '0;
    hit = 0;
    slot = 0;
    for (int unsigned i = 0; i < src_count; i++)
      if (!hit && src_keys[i] == r.src_address) begin
        slot = i;
        hit = 1;
      end
    if (!hit) begin
      if (src_count >= NSRC) o.table_full = 1'b1;
      else begin
        slot = src_count;
        src_keys[slot] = r.src_address;
        hp_cnt[slot] = 0;
        ov_cnt[slot] = 0;
        port_cnt[slot] = 0;
        src_count++;
        hit = 1;
      end
    end
    if (hit) begin
      if (r.dest_port > LOW_PORT_BOUND && r.dest_port < TOP_PORT &&
          !(r.service_code >= SVC_SMTP && r.service_code <= SVC_FTP)) begin
        hp_cnt[slot] = bump(hp_cnt[slot]);
        if (hp_cnt[slot] > lim_backdoor) begin
          o.backdoor_hit = 1'b1;
          sum_backdoor = bump(sum_backdoor);
        end
      end
      if (r.flow_packets > lim_packets || r.src_byte_count > lim_bytes ||
          r.dst_byte_count > lim_bytes) begin
        ov_cnt[slot] = bump(ov_cnt[slot]);
        if (ov_cnt[slot] > lim_dos_event) begin
          o.dos_hit = 1'b1;
          sum_dos = bump(sum_dos);
        end
      end
      known = 0;
      for (int unsigned i = 0; i < port_cnt[slot]; i++)
        if (port_store[slot][i] == r.dest_port) known = 1;
      if (!known) begin
        if (port_cnt[slot] >= NPORT) o.port_list_full = 1'b1;
        else begin
          port_store[slot][port_cnt[slot]] = r.dest_port;
          port_cnt[slot]++;
          if (port_cnt[slot] > lim_recon) begin
            o.recon_hit = 1'b1;
            sum_recon = bump(sum_recon);
          end
        end
      end
    end
    o.backdoor_total = sum_backdoor;
    o.dos_total = sum_dos;
    o.recon_total = sum_recon;
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst && done) begin
      if (verdicts_due.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        e = verdicts_due.pop_front();
        if (result.backdoor_hit !== e.backdoor_hit) begin
          $error("backdoor_hit exp %0d got %0d", e.backdoor_hit, result.backdoor_hit);
          errors++;
        end
        if (result.dos_hit !== e.dos_hit) begin
          $error("dos_hit exp %0d got %0d", e.dos_hit, result.dos_hit);
          errors++;
        end
        if (result.recon_hit !== e.recon_hit) begin
          $error("recon_hit exp %0d got %0d", e.recon_hit, result.recon_hit);
          errors++;
        end
        if (result.table_full !== e.table_full) begin
          $error("table_full exp %0d got %0d", e.table_full, result.table_full);
          errors++;
        end
        if (result.port_list_full !== e.port_list_full) begin
          $error("port_list_full exp %0d got %0d", e.port_list_full,
                 result.port_list_full);
          errors++;
        end
        if (result.backdoor_total !== e.backdoor_total) begin
          $error("backdoor_total exp %0d got %0d", e.backdoor_total,
                 result.backdoor_total);
          errors++;
        end
        if (result.dos_total !== e.dos_total) begin
          $error("dos_total exp %0d got %0d", e.dos_total, result.dos_total);
          errors++;
        end
        if (result.recon_total !== e.recon_total) begin
          $error("recon_total exp %0d got %0d", e.recon_total, result.recon_total);
          errors++;
        end
      end
    end
  end

  // The task returns at the falling edge after acceptance with start still
  // high; the next call or drain() takes it low.
  task automatic send_flow(input in_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    item <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    verdicts_due.push_back(score_flow(r));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (NSRC + NPORT + 20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_BACKDOOR_LIMIT: lim_backdoor = {16'd0, val[15:0]};
      REG_DOS_EVENT_LIMIT: lim_dos_event = {16'd0, val[15:0]};
      REG_RECON_LIMIT: lim_recon = {16'd0, val[15:0]};
      REG_DOS_BYTE_LIMIT: lim_bytes = val;
      REG_DOS_PACKET_LIMIT: lim_packets = val;
      default: ;
    endcase
  endtask

  function automatic in_t mk_flow(input logic [31:0] a, input logic [15:0] p,
                                  input logic [2:0] s, input logic [31:0] sb,
                                  input logic [31:0] db, input logic [31:0] pk);
    in_t r;
    r.src_address = a;
    r.dest_port = p;
    r.service_code = s;
    r.src_byte_count = sb;
    r.dst_byte_count = db;
    r.flow_packets = pk;
    return r;
  endfunction

  function automatic in_t rand_flow(input int nkeys);
    in_t r;
    r.src_address = 32'hA000_0000 + $urandom_range(nkeys - 1);
    case ($urandom_range(3))
      0: r.dest_port = 16'($urandom);
      1: r.dest_port = 16'($urandom_range(1030, 1020));
      2: r.dest_port = 16'(16'hFFFF - $urandom_range(2));
      default: r.dest_port = 16'(16'd2000 + $urandom_range(79));
    endcase
    r.service_code = 3'($urandom);
    r.src_byte_count = $urandom_range(1) ? $urandom : lim_bytes + $urandom_range(2) - 1;
    r.dst_byte_count = $urandom_range(1) ? $urandom : $urandom_range(200000);
    r.flow_packets = $urandom_range(1) ? $urandom : lim_packets + $urandom_range(2) - 1;
    return r;
  endfunction

  task automatic test_directed();
    send_flow(mk_flow(32'h0, 16'd0, 3'd0, 32'd0, 32'd0, 32'd0));
    send_flow(mk_flow(32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_flow(mk_flow(32'h1, 16'd1024, 3'd5, 32'd100000, 32'd100001, 32'd1000));
    send_flow(mk_flow(32'h1, 16'd1025, 3'd6, 32'd0, 32'd0, 32'd1001));
    send_flow(mk_flow(32'h1, 16'd65534, 3'd0, 32'd100001, 32'd0, 32'd0));
    for (int s = 1; s <= 4; s++)
      send_flow(mk_flow(32'h1, 16'(16'd3000 + s), s[2:0], 32'd0, 32'd0, 32'd5000));
    send_flow(mk_flow(32'h1, 16'd3001, 3'd0, 32'd0, 32'd0, 32'd0));
  endtask

  task automatic test_thresholds();
    drain();
    write_reg(REG_BACKDOOR_LIMIT, 32'd0);
    write_reg(REG_DOS_EVENT_LIMIT, 32'd0);
    write_reg(REG_RECON_LIMIT, 32'd0);
    write_reg(REG_DOS_BYTE_LIMIT, 32'd0);
    write_reg(REG_DOS_PACKET_LIMIT, 32'd0);
    write_reg(3'd7, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_flow(rand_flow(4));
    drain();
    write_reg(REG_BACKDOOR_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_DOS_EVENT_LIMIT, 32'hFFFF);
    write_reg(REG_RECON_LIMIT, 32'hFFFF);
    write_reg(REG_DOS_BYTE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_DOS_PACKET_LIMIT, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_flow(rand_flow(4));
    drain();
    write_reg(REG_BACKDOOR_LIMIT, 32'd2);
    write_reg(REG_DOS_EVENT_LIMIT, 32'd1);
    write_reg(REG_RECON_LIMIT, 32'd3);
    write_reg(REG_DOS_BYTE_LIMIT, 32'd100000);
    write_reg(REG_DOS_PACKET_LIMIT, 32'd1000);
  endtask

  task automatic test_port_list_full();
    for (int p = 0; p < NPORT + 3; p++)
      send_flow(mk_flow(32'h5, 16'(16'd40000 + p), 3'd0, 32'd0, 32'd0, 32'd0));
    send_flow(mk_flow(32'h5, 16'd40000, 3'd0, 32'd0, 32'd0, 32'd2000));
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 200; i++) begin
      if (i == 60) idle_pct = 0;
      if (i == 120) idle_pct = 35;
      send_flow(rand_flow(i < 100 ? 12 : 40));
    end
  endtask

  task automatic test_table_full();
    for (int i = 0; src_count < NSRC; i++)
      send_flow(mk_flow(32'(32'hC000_0000 + i), 16'($urandom), 3'($urandom),
                        $urandom_range(200000), $urandom_range(200000),
                        $urandom_range(2000)));
    for (int i = 0; i < 80; i++) begin
      in_t r;
      r = rand_flow(40);
      if ($urandom_range(2) == 0) r.src_address = $urandom | 32'h0000_0001;
      send_flow(r);
    end
  endtask

  initial begin
    lim_backdoor = BACKDOOR_LIMIT_RST;
    lim_dos_event = DOS_EVENT_LIMIT_RST;
    lim_recon = RECON_LIMIT_RST;
    lim_bytes = DOS_BYTE_LIMIT_RST;
    lim_packets = DOS_PACKET_LIMIT_RST;
    src_count = 0;
    sum_backdoor = 0;
    sum_dos = 0;
    sum_recon = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_thresholds();
    test_port_list_full();
    test_random_traffic();
    test_table_full();
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/psic_pkg.sv
sv/psic_ram.sv
sv/psic_controller.sv
sv/psic_datapath.sv
sv/per_source_intrusion_counter.sv
tb/tb_top.sv
